// File: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

// File: hdl/dd_pkg.sv
`default_nettype none

package dd_pkg;

   localparam int DateW   = 27;
   localparam int CountW  = 22;
   localparam int YearW   = 14;
   localparam int DayNumW = 23;

   localparam logic [DateW-1:0]  MaxDate  = 27'd99999999;
   localparam logic [CountW-1:0] MaxCount = 22'd3652425;

   // Reciprocals for division by 625 (after a shift by 4) and by 25 (after a shift by 2).
   localparam logic [23:0] Div625Mul   = 24'd13743896;
   localparam logic [11:0] Div25Mul    = 12'd2622;
   localparam logic [13:0] YearScale   = 14'd10000;
   localparam logic [13:0] CenturyBase = 14'd400;

   typedef struct packed {
      logic                 ok;
      logic [DayNumW-1:0]   num;
   } dd_day_type;

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      case (m)
         4'd2:                      len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

   // Days before the month in a year that starts in March.
   function automatic logic [8:0] month_offset(input logic [3:0] m);
      logic [8:0] off;
      case (m)
         4'd1:    off = 9'd306;
         4'd2:    off = 9'd337;
         4'd3:    off = 9'd0;
         4'd4:    off = 9'd31;
         4'd5:    off = 9'd61;
         4'd6:    off = 9'd92;
         4'd7:    off = 9'd122;
         4'd8:    off = 9'd153;
         4'd9:    off = 9'd184;
         4'd10:   off = 9'd214;
         4'd11:   off = 9'd245;
         4'd12:   off = 9'd275;
         default: off = 9'd0;
      endcase
      return off;
   endfunction

endpackage

`default_nettype wire

// File: hdl/date_difference_days_top.sv
`default_nettype none
// Inclusive Gregorian day count between two dates given as YYYYMMDD integers.
// Input channel: a transfer takes place at a rising clock edge with start high
// and busy low. busy is always low, so a new date pair may be sent every cycle.
// Result channel: rsp_valid is high for exactly one cycle per transfer and
// marks rsp_day_count and rsp_bad_date. The receiver cannot hold results off,
// and none is needed since the pipeline never stops.
// The result reaches the ports through nine register stages: the
// seven-stage date-to-day-number pipeline, one stage that orders the two day
// numbers and subtracts them, and the result register.
// Throughput: one transfer per cycle, results in transfer order.
// A date is flagged when its value is above 99999999, its month is outside
// 1 to 12, or its day is outside the month; the count is then zero.
// Reset clears all valid bits, so no result appears from earlier transfers;
// the payload registers are not reset.

`include "assert_macros.svh"

module date_difference_days_top import dd_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output wire logic              busy,
   input  wire logic [DateW-1:0]  req_first_date,
   input  wire logic [DateW-1:0]  req_second_date,
   output wire logic              rsp_valid,
   output wire logic [CountW-1:0] rsp_day_count,
   output wire logic              rsp_bad_date
);

   localparam int UnitDepth = 7;

   dd_day_type             day_a;
   dd_day_type             day_b;

   logic [UnitDepth-1:0]   vld_ff, vld_in;
   logic                   diff_vld_ff;
   logic [DayNumW-1:0]     diff_ff, diff_in;
   logic                   bad_ff, bad_in;
   logic                   rsp_valid_ff;
   logic [CountW-1:0]      rsp_day_count_ff, rsp_day_count_in;
   logic                   rsp_bad_date_ff;

   dd_day_num u_first (
      .clock (clock),
      .date  (req_first_date),
      .day   (day_a)
   );

   dd_day_num u_second (
      .clock (clock),
      .date  (req_second_date),
      .day   (day_b)
   );

   assign busy = 1'b0;

   always_comb begin
      vld_in  = {vld_ff[UnitDepth-2:0], start && !busy};
      diff_in = (day_b.num >= day_a.num) ? (day_b.num - day_a.num) : (day_a.num - day_b.num);
      bad_in  = !(day_a.ok && day_b.ok);
      rsp_day_count_in = bad_ff ? '0 : (diff_ff[CountW-1:0] + 22'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         diff_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= vld_in;
         diff_vld_ff  <= vld_ff[UnitDepth-1];
         rsp_valid_ff <= diff_vld_ff;
      end
      diff_ff          <= diff_in;
      bad_ff           <= bad_in;
      rsp_day_count_ff <= rsp_day_count_in;
      rsp_bad_date_ff  <= bad_ff;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_day_count = rsp_day_count_ff;
   assign rsp_bad_date  = rsp_bad_date_ff;

   `ASSERT_IMPLIES(bad_gives_zero, clock, reset, rsp_valid && rsp_bad_date, rsp_day_count == '0)
   `ASSERT_IMPLIES(good_not_zero, clock, reset, rsp_valid && !rsp_bad_date, rsp_day_count != '0)
   `ASSERT_IMPLIES(count_in_range, clock, reset, rsp_valid, rsp_day_count <= MaxCount)
   `ASSERT_NEXT(diff_to_result, clock, reset, diff_vld_ff, rsp_valid)

endmodule

`default_nettype wire

// File: hdl/dd_day_num.sv
`default_nettype none

module dd_day_num import dd_pkg::*; (
   input  wire logic             clock,
   input  wire logic [DateW-1:0] date,
   output dd_day_type            day
);

   logic [YearW-1:0]   year1_ff, year1_in;
   logic [DateW-1:0]   date1_ff;
   logic               over1_ff, over1_in;

   logic [YearW-1:0]   year2_ff;
   logic [13:0]        rem2_ff, rem2_in;
   logic               over2_ff;

   logic [YearW-1:0]   year3_ff;
   logic [13:0]        rem3_ff;
   logic [6:0]         month3_ff, month3_in;
   logic [7:0]         cent3_ff, cent3_in;
   logic               over3_ff;

   logic [YearW-1:0]   year4_ff;
   logic [6:0]         month4_ff;
   logic [6:0]         mday4_ff, mday4_in;
   logic [7:0]         cent4_ff;
   logic [6:0]         yrem4_ff, yrem4_in;
   logic               over4_ff;

   logic               ok5_ff, ok5_in;
   logic [YearW-1:0]   yp5_ff, yp5_in;
   logic [7:0]         cp5_ff, cp5_in;
   logic [8:0]         moff5_ff, moff5_in;
   logic [4:0]         mday5_ff;

   logic               ok6_ff;
   logic [DayNumW-1:0] base6_ff, base6_in;
   logic [9:0]         small6_ff, small6_in;
   logic [7:0]         cp6_ff;

   dd_day_type         day7_ff, day7_in;

   logic [46:0] prod1;
   logic [26:0] scaled2;
   logic [26:0] diff2;
   logic [23:0] prod3_m;
   logic [23:0] prod3_c;
   logic [13:0] diff4_d;
   logic [13:0] diff4_y;
   logic        leap5;
   logic        adj5;
   logic        month_ok5;
   logic [4:0]  len5;

   always_comb begin
      prod1    = 47'(date[DateW-1:4]) * 47'(Div625Mul);
      year1_in = prod1[46:33];
      over1_in = date > MaxDate;

      scaled2 = 27'(year1_ff) * 27'(YearScale);
      diff2   = date1_ff - scaled2;
      rem2_in = diff2[13:0];

      prod3_m   = 24'(rem2_ff[13:2]) * 24'(Div25Mul);
      prod3_c   = 24'(year2_ff[13:2]) * 24'(Div25Mul);
      month3_in = prod3_m[22:16];
      cent3_in  = prod3_c[23:16];

      diff4_d  = rem3_ff - 14'(month3_ff) * 14'd100;
      diff4_y  = year3_ff - 14'(cent3_ff) * 14'd100;
      mday4_in = diff4_d[6:0];
      yrem4_in = diff4_y[6:0];

      leap5     = (yrem4_ff == 7'd0) ? (cent4_ff[1:0] == 2'd0) : (year4_ff[1:0] == 2'd0);
      month_ok5 = month4_ff inside {[7'd1:7'd12]};
      len5      = month_len(month4_ff[3:0], leap5);
      ok5_in    = !over4_ff && month_ok5 && (mday4_ff != 7'd0) && (mday4_ff <= 7'(len5));
      adj5      = month4_ff <= 7'd2;
      yp5_in    = year4_ff + CenturyBase - 14'(adj5);
      cp5_in    = cent4_ff + ((adj5 && yrem4_ff == 7'd0) ? 8'd3 : 8'd4);
      moff5_in  = month_offset(month4_ff[3:0]);

      base6_in  = 23'(yp5_ff) * 23'd365 + 23'(yp5_ff[13:2]);
      small6_in = 10'(moff5_ff) + 10'(mday5_ff) + 10'(cp5_ff[7:2]);

      day7_in.ok  = ok6_ff;
      day7_in.num = base6_ff + 23'(small6_ff) - 23'(cp6_ff);
   end

   always_ff @(posedge clock) begin
      year1_ff  <= year1_in;
      date1_ff  <= date;
      over1_ff  <= over1_in;

      year2_ff  <= year1_ff;
      rem2_ff   <= rem2_in;
      over2_ff  <= over1_ff;

      year3_ff  <= year2_ff;
      rem3_ff   <= rem2_ff;
      month3_ff <= month3_in;
      cent3_ff  <= cent3_in;
      over3_ff  <= over2_ff;

      year4_ff  <= year3_ff;
      month4_ff <= month3_ff;
      mday4_ff  <= mday4_in;
      cent4_ff  <= cent3_ff;
      yrem4_ff  <= yrem4_in;
      over4_ff  <= over3_ff;

      ok5_ff    <= ok5_in;
      yp5_ff    <= yp5_in;
      cp5_ff    <= cp5_in;
      moff5_ff  <= moff5_in;
      mday5_ff  <= mday4_ff[4:0];

      ok6_ff    <= ok5_ff;
      base6_ff  <= base6_in;
      small6_ff <= small6_in;
      cp6_ff    <= cp5_ff;

      day7_ff   <= day7_in;
   end

   assign day = day7_ff;

endmodule

`default_nettype wire
